// File: hdl/bq_pkg.sv
// ----------------------------------------------------------------------------
// bq_pkg
// Shared types and constants for the biquad filter: coefficient format,
// register map and coefficient reset values.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int COEF_WIDTH = 24;
  localparam int NUM_COEFS  = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  localparam coef_t COEF_B0_RESET = 24'sd4194304;
  localparam coef_t COEF_ZERO     = 24'sd0;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

endpackage

// File: hdl/bq_coef_regs.sv
// ----------------------------------------------------------------------------
// bq_coef_regs
// APB register file for the five Q2.22 coefficients. A write to a valid
// register also pulses hist_clr so the filter history restarts.
// ----------------------------------------------------------------------------
module bq_coef_regs
  import bq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output coef_set_t             coefs,
  output logic                  hist_clr
);

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  logic                 idx_ok;
  coef_t                wcoef;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign idx_ok = (idx < REG_IDX_W'(NUM_COEFS));
  assign wcoef  = coef_t'(pwdata[COEF_WIDTH-1:0]);
  assign pready = 1'b1;

  assign hist_clr = wr_en && idx_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= COEF_B0_RESET;
      coefs.b1 <= COEF_ZERO;
      coefs.b2 <= COEF_ZERO;
      coefs.a1 <= COEF_ZERO;
      coefs.a2 <= COEF_ZERO;
    end else if (wr_en) begin
      case (idx)
        REG_B0:  coefs.b0 <= wcoef;
        REG_B1:  coefs.b1 <= wcoef;
        REG_B2:  coefs.b2 <= wcoef;
        REG_A1:  coefs.a1 <= wcoef;
        REG_A2:  coefs.a2 <= wcoef;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_B0:  prdata = APB_DATA_W'(coefs.b0);
      REG_B1:  prdata = APB_DATA_W'(coefs.b1);
      REG_B2:  prdata = APB_DATA_W'(coefs.b2);
      REG_A1:  prdata = APB_DATA_W'(coefs.a1);
      REG_A2:  prdata = APB_DATA_W'(coefs.a2);
      default: prdata = '0;
    endcase
  end

endmodule

// File: hdl/bq_mac.sv
// ----------------------------------------------------------------------------
// bq_mac
// Five parallel products summed exactly, rounded half up from the
// coefficient grid to the sample grid, then saturated with a clip flag.
// ----------------------------------------------------------------------------
module bq_mac
  import bq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 22
) (
  input  coef_set_t                       coefs,
  input  logic signed [SAMPLE_WIDTH-1:0]  x0,
  input  logic signed [SAMPLE_WIDTH-1:0]  x1,
  input  logic signed [SAMPLE_WIDTH-1:0]  x2,
  input  logic signed [SAMPLE_WIDTH-1:0]  y1,
  input  logic signed [SAMPLE_WIDTH-1:0]  y2,
  output logic signed [SAMPLE_WIDTH-1:0]  y,
  output logic                            clip
);

  localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + 3;
  localparam int HI_W   = ACC_W - SAMPLE_WIDTH + 1;

  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  q;
  logic [HI_W-1:0]          hi;
  logic                     in_range;

  assign p_b0 = coefs.b0 * x0;
  assign p_b1 = coefs.b1 * x1;
  assign p_b2 = coefs.b2 * x2;
  assign p_a1 = coefs.a1 * y1;
  assign p_a2 = coefs.a2 * y2;

  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2) + RND;

  assign q        = acc >>> COEF_FRAC_BITS;
  assign hi       = q[ACC_W-1:SAMPLE_WIDTH-1];
  assign in_range = (hi == '0) || (hi == '1);

  always_comb begin
    clip = !in_range;
    if (in_range) begin
      y = q[SAMPLE_WIDTH-1:0];
    end else if (q[ACC_W-1]) begin
      y = SMIN;
    end else begin
      y = SMAX;
    end
  end

endmodule

// File: hdl/biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Direct form I biquad: y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded
// and saturated to the sample format, with APB coefficient registers.
//
//   channel   signals                                     beat
//   input     in_valid / in_ready / sample_in             one sample
//   output    out_valid / out_ready / sample_out,clipped  one filtered sample
//   config    psel penable pwrite paddr pwdata prdata     one coefficient
//
// One beat per cycle while the output is not stalled; an accepted sample
// passes the input register, then MAC and saturation into the output register.
// The output feedback path y1 -> MAC -> y1 closes through the prev_out register.
// Reset restores the coefficients and clears history; a coefficient write
// clears history. A stalled output holds both registers once in_vld is set.
// ----------------------------------------------------------------------------
module biquad_iir_filter
  import bq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [APB_ADDR_W-1:0]           paddr,
  input  logic [APB_DATA_W-1:0]           pwdata,
  output logic [APB_DATA_W-1:0]           prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out,
  output logic                            clipped
);

  coef_set_t                      coefs;
  logic                           hist_clr;
  logic                           in_vld;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic signed [SAMPLE_WIDTH-1:0] prev_in, prev_in_2, prev_out, prev_out_2;
  logic signed [SAMPLE_WIDTH-1:0] y;
  logic                           clip;
  logic                           advance;

  bq_coef_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .coefs    (coefs),
    .hist_clr (hist_clr)
  );

  bq_mac #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .coefs (coefs),
    .x0    (in_sample),
    .x1    (prev_in),
    .x2    (prev_in_2),
    .y1    (prev_out),
    .y2    (prev_out_2),
    .y     (y),
    .clip  (clip)
  );

  assign advance  = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_sample <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= y;
      clipped    <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || hist_clr) begin
      prev_in    <= '0;
      prev_in_2  <= '0;
      prev_out   <= '0;
      prev_out_2 <= '0;
    end else if (advance) begin
      prev_in    <= in_sample;
      prev_in_2  <= prev_in;
      prev_out   <= y;
      prev_out_2 <= prev_out;
    end
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Biquad filter bench. Runs a table of directed samples and coefficient
// writes, then random coefficient sets with random sample streams under
// three idle patterns. Each accepted beat is predicted in-bench and every
// output beat is checked in order against that prediction or a typed table value.
// ----------------------------------------------------------------------------
module tb_top
  import bq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_FRAC   = 22;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 26;
  localparam int PHASE_BEATS = 61;
  localparam longint SMAX    = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SMIN    = -SMAX - 1;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(NUM_COEFS);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sample_out;
    logic    clipped;
  } out_beat_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [APB_ADDR_W-1:0] addr;
    logic [APB_DATA_W-1:0] data;
    sample_t               x;
    logic                  typed;
    sample_t               y;
    logic                  clip;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sample_t               sample_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sample_t               sample_out;
  logic                  clipped;

  coef_t     coef_q [NUM_COEFS];
  sample_t   hist_x1, hist_x2, hist_y1, hist_y2;
  out_beat_t filtered_q [$];
  out_beat_t want;
  dir_row_t  dir_rows [DIR_ROWS];
  int        idle_in_pct = 0;
  int        idle_out_pct = 0;
  int        err_count = 0;
  int        cycle_count = 0;

  biquad_iir_filter #(
    .SAMPLE_WIDTH   (SAMPLE_W),
    .COEF_FRAC_BITS (COEF_FRAC)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  always #4 clk = ~clk;

  function automatic out_beat_t filter_step(input sample_t x);
    longint    acc;
    out_beat_t r;
    acc = longint'(coef_q[REG_B0]) * longint'(x)
        + longint'(coef_q[REG_B1]) * longint'(hist_x1)
        + longint'(coef_q[REG_B2]) * longint'(hist_x2)
        - longint'(coef_q[REG_A1]) * longint'(hist_y1)
        - longint'(coef_q[REG_A2]) * longint'(hist_y2);
    acc = acc + (longint'(1) <<< (COEF_FRAC - 1));
    acc = acc >>> COEF_FRAC;
    r.clipped = 1'b0;
    if (acc > SMAX) begin
      acc = SMAX;
      r.clipped = 1'b1;
    end else if (acc < SMIN) begin
      acc = SMIN;
      r.clipped = 1'b1;
    end
    r.sample_out = sample_t'(acc);
    hist_x2 = hist_x1;
    hist_x1 = x;
    hist_y2 = hist_y1;
    hist_y1 = r.sample_out;
    return r;
  endfunction

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    logic [REG_IDX_W-1:0] idx;
    idx = addr[APB_ADDR_W-1:2];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < NUM_COEFS) begin
      coef_q[idx] = data[COEF_WIDTH-1:0];
      hist_x1 = '0;
      hist_x2 = '0;
      hist_y1 = '0;
      hist_y2 = '0;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays up across back-to-back beats; it only drops for an idle gap
  task automatic push_sample(input sample_t x, input logic typed, input out_beat_t typed_beat);
    out_beat_t beat;
    if ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_in_pct);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
    beat = filter_step(x);
    filtered_q.push_back(typed ? typed_beat : beat);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_out_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $error("sample_out: beat with nothing pending, got %0d", sample_out);
        err_count++;
      end else begin
        want = filtered_q.pop_front();
        if (sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, sample_out);
          err_count++;
        end
        if (clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, clipped);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [APB_DATA_W-1:0] word;
    logic [REG_IDX_W-1:0]  reg_idx;
    sample_t               x;
    int                    lp_k;

    coef_q[REG_B0] = COEF_B0_RESET;
    coef_q[REG_B1] = COEF_ZERO;
    coef_q[REG_B2] = COEF_ZERO;
    coef_q[REG_A1] = COEF_ZERO;
    coef_q[REG_A2] = COEF_ZERO;
    hist_x1 = '0;
    hist_x2 = '0;
    hist_y1 = '0;
    hist_y2 = '0;

    // reset coefs give y = x; max gain of +/-2.0 clips both rails
    dir_rows = '{
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b1, 16'sh8000, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sh0000, 1'b1, 16'sh0000, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sh0001, 1'b1, 16'sh0001, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'shFFFF, 1'b1, 16'shFFFF, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sh5555, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'shAAAA, 1'b0, '0, 1'b0},
      '{ROW_WRITE, {REG_B0, 2'b00}, 32'hFF7F_FFFF, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b1, 16'sh8000, 1'b1},
      '{ROW_SAMPLE, '0, '0, 16'sd100, 1'b0, '0, 1'b0},
      '{ROW_WRITE, {REG_B0, 2'b00}, 32'h0080_0000, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b1, 16'sh7FFF, 1'b1},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1},
      '{ROW_WRITE, {REG_B1, 2'b00}, 32'h5A40_0000, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sd1000, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, -16'sd500, 1'b0, '0, 1'b0},
      '{ROW_WRITE, {REG_UNMAPPED, 2'b00}, 32'h1234_5678, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sd7, 1'b0, '0, 1'b0},
      '{ROW_WRITE, {REG_B2, 2'b00}, 32'h00C0_0000, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, {REG_A1, 2'b00}, 32'h00A0_0000, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, {REG_A2, 2'b00}, 32'h0030_0000, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sd20000, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, -16'sd20000, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sh0000, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, '0, 16'sh0000, 1'b0, '0, 1'b0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        apb_write(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        push_sample(dir_rows[i].x, dir_rows[i].typed, {dir_rows[i].y, dir_rows[i].clip});
      end
    end

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          idle_in_pct  = 22;
          idle_out_pct = 72;
        end
        1: begin
          idle_in_pct  = 72;
          idle_out_pct = 22;
        end
        default: begin
          idle_in_pct  = 0;
          idle_out_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 6; ph++) begin
        wait_drained();
        lp_k = int'($urandom_range(300000, 20000));
        for (int r = 0; r < NUM_COEFS; r++) begin
          reg_idx = REG_IDX_W'(r);
          case (ph)
            0: word = {8'($urandom), 24'h7F_FFFF};
            1: word = {8'($urandom), 24'h80_0000};
            2: word = $urandom;
            3: begin
              // stable low-pass around a1 = -1.6, a2 = 0.64
              case (reg_idx)
                REG_B0, REG_B2: word = 32'(lp_k);
                REG_B1: word = 32'(2 * lp_k);
                REG_A1: word = 32'(-6710886 + int'($urandom_range(400000)) - 200000);
                default: word = 32'(2684354 + int'($urandom_range(400000)) - 200000);
              endcase
            end
            4: word = 32'($signed(22'($urandom)));
            default: word = (reg_idx == REG_B0) ? $urandom : {8'($urandom), 24'h0};
          endcase
          apb_write({reg_idx, 2'b00}, word);
        end
        for (int s = 0; s < PHASE_BEATS; s++) begin
          if (s == PHASE_BEATS / 2 && $urandom_range(1) == 1) begin
            wait_drained();
            reg_idx = REG_IDX_W'($urandom_range(2 ** REG_IDX_W - 1, NUM_COEFS));
            apb_write({reg_idx, 2'b00}, $urandom);
          end
          case ($urandom_range(9))
            0: x = 16'sh7FFF;
            1: x = 16'sh8000;
            2: x = sample_t'(int'($urandom_range(64)) - 32);
            default: x = sample_t'($urandom);
          endcase
          push_sample(x, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
